FILE: hw/rtl/qcbf_pkg.sv
// ----------------------------------------------------------------------------
// qcbf_pkg
// shared constants for the qc-mdpc bit-flipping decoder
// ----------------------------------------------------------------------------
`default_nettype none
package qcbf_pkg;
    localparam int unsigned WORD_W   = 24;
    localparam int unsigned MSG_W    = 18;
    localparam int unsigned MARGIN_W = 6;
    localparam int unsigned ITER_W   = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

    localparam logic [MARGIN_W-1:0] MARGIN_RST   = 6'd5;
    localparam logic [ITER_W-1:0]   MAX_ITER_RST = 6'd10;

    typedef logic [WORD_W-1:0] t_word;
endpackage
`default_nettype wire

FILE: hw/rtl/qcbf_in_if.sv
// ----------------------------------------------------------------------------
// qcbf_in_if
// input channel: received word with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none
interface qcbf_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] received_word;
    modport source (output valid, output received_word, input ready);
    modport sink   (input valid, input received_word, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/qcbf_out_if.sv
// ----------------------------------------------------------------------------
// qcbf_out_if
// output channel: decoded message, status and iteration count
// ----------------------------------------------------------------------------
`default_nettype none
interface qcbf_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] message;
    logic        status;
    logic [5:0]  iterations_used;
    modport source (output valid, output message, output status,
                    output iterations_used, input ready);
    modport sink   (input valid, input message, input status,
                    input iterations_used, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/qc_mdpc_bit_flip_decoder.sv
// ----------------------------------------------------------------------------
// qc_mdpc_bit_flip_decoder
// iterative bit-flipping decoder for a quasi-cyclic mdpc code
// ----------------------------------------------------------------------------
// One item is decoded at a time. A shared column unit walks the code
// positions one per cycle: a pass over all N = BLOCK_COUNT*CIRC_SIZE
// positions (24 with the default parameters) builds the syndrome and a
// check state follows. Each flip iteration makes one pass to find the
// largest unsatisfied-check count, one pass to flip bits at or above the
// threshold, one column at a time, and one check state. The result is then
// held in the output state until it is taken. Column j of the parity
// matrix is the key segment of its block rotated, formed each cycle from
// the key register. The result sits in an output register; the input is
// not ready while an item is being decoded or its result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module qc_mdpc_bit_flip_decoder #(
    parameter int unsigned CIRC_SIZE   = 6,
    parameter int unsigned BLOCK_COUNT = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [qcbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [qcbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    qcbf_in_if.sink                            in_ch,
    qcbf_out_if.source                         out_ch
);
    import qcbf_pkg::*;

    localparam int unsigned N     = BLOCK_COUNT * CIRC_SIZE;
    localparam int unsigned K     = (BLOCK_COUNT - 1) * CIRC_SIZE;
    localparam int unsigned POS_W = $clog2(N);
    localparam int unsigned CNT_W = $clog2(CIRC_SIZE + 1);
    localparam int unsigned CS_W  = $clog2(CIRC_SIZE);
    localparam int unsigned BLK_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SYN  = 3'd1;
    localparam logic [2:0] ST_MAX  = 3'd2;
    localparam logic [2:0] ST_FLIP = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [N-1:0]         r_key;
    logic [MARGIN_W-1:0]  r_margin;
    logic [ITER_W-1:0]    r_max_iter;

    logic [2:0]           r_state, n_state;
    logic [N-1:0]         r_word, n_word;
    logic [CIRC_SIZE-1:0] r_syn, n_syn;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [CS_W-1:0]      r_c, n_c;       // position within block
    logic [BLK_W-1:0]     r_blk, n_blk;   // block of current position
    logic [CNT_W-1:0]     r_top, n_top;
    logic [ITER_W-1:0]    r_iter, n_iter;
    logic                 r_status, n_status;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_margin   <= MARGIN_RST;
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_ROW:  r_key      <= i_cfg_data[N-1:0];
                REG_MARGIN:   r_margin   <= i_cfg_data[MARGIN_W-1:0];
                REG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // shared column unit: column of the current position and its count
    logic [CIRC_SIZE-1:0] w_seg;
    logic [CIRC_SIZE-1:0] w_col;
    logic [CNT_W-1:0]     w_cnt;
    logic [CIRC_SIZE-1:0] w_upd;
    logic [CS_W-1:0]      w_sel;

    always_comb begin
        w_seg = r_key[r_blk*CIRC_SIZE +: CIRC_SIZE];
        w_sel = '0;
        for (int r = 0; r < CIRC_SIZE; r++) begin
            // H[r][c] = seg[(c - r) mod CIRC_SIZE]
            if (r_c >= CS_W'(r)) begin
                w_sel = r_c - CS_W'(r);
            end else begin
                w_sel = r_c + CS_W'(CIRC_SIZE - r);
            end
            w_col[r] = w_seg[w_sel];
        end
        w_upd = w_col & r_syn;
        w_cnt = '0;
        for (int r = 0; r < CIRC_SIZE; r++) begin
            w_cnt = w_cnt + CNT_W'(w_upd[r]);
        end
    end

    // flip when count + margin >= top
    logic w_flip;
    assign w_flip = ({1'b0, MARGIN_W'(w_cnt)} + {1'b0, r_margin}) >=
                    {1'b0, MARGIN_W'(r_top)};

    logic w_last;
    assign w_last = (r_pos == POS_W'(N - 1));

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_syn    = r_syn;
        n_pos    = r_pos;
        n_c      = r_c;
        n_blk    = r_blk;
        n_top    = r_top;
        n_iter   = r_iter;
        n_status = r_status;
        if (r_state == ST_SYN || r_state == ST_MAX || r_state == ST_FLIP) begin
            if (w_last) begin
                n_pos = '0;
                n_c   = '0;
                n_blk = '0;
            end else begin
                n_pos = r_pos + 1'b1;
                if (r_c == CS_W'(CIRC_SIZE - 1)) begin
                    n_c   = '0;
                    n_blk = r_blk + 1'b1;
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_ch.valid) begin
                    n_word = in_ch.received_word[N-1:0];
                    n_syn  = '0;
                    n_pos  = '0;
                    n_c    = '0;
                    n_blk  = '0;
                    n_iter = '0;
                    n_state = ST_SYN;
                end
            end
            ST_SYN: begin
                if (r_word[r_pos]) n_syn = r_syn ^ w_col;
                if (w_last) n_state = ST_CHK;
            end
            ST_CHK: begin
                // end of syndrome build or of one iteration
                n_top = '0;
                if (r_syn == '0) begin
                    n_status = 1'b0;
                    n_state  = ST_OUT;
                end else if (r_iter >= r_max_iter) begin
                    n_status = 1'b1;
                    n_state  = ST_OUT;
                end else begin
                    n_state = ST_MAX;
                end
            end
            ST_MAX: begin
                if (w_cnt > r_top) n_top = w_cnt;
                if (w_last) n_state = ST_FLIP;
            end
            ST_FLIP: begin
                // counts use the syndrome frozen at iteration start
                if (w_flip) begin
                    n_word[r_pos] = ~r_word[r_pos];
                end
                if (w_last) begin
                    n_iter  = r_iter + 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_OUT: begin
                if (out_ch.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // syndrome update accumulated separately so counts stay frozen in flip pass
    logic [CIRC_SIZE-1:0] r_acc;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAX) begin
            r_acc <= '0;
        end else if (r_state == ST_FLIP && w_flip) begin
            r_acc <= r_acc ^ w_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_word   <= n_word;
        r_pos    <= n_pos;
        r_c      <= n_c;
        r_blk    <= n_blk;
        r_top    <= n_top;
        r_iter   <= n_iter;
        r_status <= n_status;
        if (r_state == ST_FLIP && w_last) begin
            r_syn <= r_syn ^ r_acc ^ (w_flip ? w_col : '0);
        end else begin
            r_syn <= n_syn;
        end
    end

    assign in_ch.ready            = (r_state == ST_IDLE);
    assign out_ch.valid           = (r_state == ST_OUT);
    assign out_ch.message         = MSG_W'(r_word[K-1:0]);
    assign out_ch.status          = r_status;
    assign out_ch.iterations_used = r_iter;

    // result never shows an iteration count above the limit
    a_iter_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.iterations_used <= r_max_iter))
        else $error("iteration count above limit");
    // success means the syndrome really is zero
    a_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.status) |-> (r_syn == '0))
        else $error("success reported with nonzero syndrome");
    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(r_word)))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

FILE: tb/qcbf_scoreboard.sv
// ----------------------------------------------------------------------------
// qcbf_scoreboard
// bit-flip decode predictor and result checker for the decoder testbench
// ----------------------------------------------------------------------------
package qcbf_tb_pkg;
    import qcbf_pkg::*;

    localparam int unsigned CIRC = 6;
    localparam int unsigned BLKS = 4;
    localparam int unsigned CODE_N = CIRC * BLKS;

    typedef struct packed {
        logic [MSG_W-1:0]  message;
        logic              status;
        logic [ITER_W-1:0] iters;
    } t_decode_res;

    class decode_scoreboard;
        logic [WORD_W-1:0]   key;
        logic [MARGIN_W-1:0] margin;
        logic [ITER_W-1:0]   iter_limit;
        t_decode_res         pending[$];
        int                  n_errors;

        function new();
            key        = '0;
            margin     = MARGIN_RST;
            iter_limit = MAX_ITER_RST;
            n_errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KEY_ROW:  key = data;
                REG_MARGIN:   margin = data[MARGIN_W-1:0];
                REG_MAX_ITER: iter_limit = data[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        // parity column of code position j, bit r set when row r checks it
        function logic [CIRC-1:0] column(int j);
            logic [CIRC-1:0] c;
            int b;
            int k;
            b = j / CIRC;
            k = j % CIRC;
            c = '0;
            for (int r = 0; r < CIRC; r++)
                c[r] = key[b*CIRC + (k + CIRC - r) % CIRC];
            return c;
        endfunction

        function t_decode_res decode(logic [WORD_W-1:0] word_in);
            logic [CIRC-1:0] cols[CODE_N];
            int              cnt[CODE_N];
            logic [CIRC-1:0] syn;
            logic [WORD_W-1:0] w;
            int              top;
            int              it;
            t_decode_res     res;
            w   = word_in;
            syn = '0;
            it  = 0;
            for (int j = 0; j < CODE_N; j++) begin
                cols[j] = column(j);
                if (w[j]) syn ^= cols[j];
            end
            res.status = (syn != 0);
            while (syn != 0 && it < iter_limit) begin
                top = 0;
                for (int j = 0; j < CODE_N; j++) begin
                    cnt[j] = $countones(cols[j] & syn);
                    if (cnt[j] > top) top = cnt[j];
                end
                // negative threshold flips every bit
                for (int j = 0; j < CODE_N; j++) begin
                    if (cnt[j] + int'(margin) >= top) begin
                        w[j] = ~w[j];
                        syn ^= cols[j];
                    end
                end
                it++;
                if (syn == 0) res.status = 1'b0;
            end
            res.message = w[MSG_W-1:0];
            res.iters   = it[ITER_W-1:0];
            return res;
        endfunction

        function void note_word(logic [WORD_W-1:0] word_in);
            pending.push_back(decode(word_in));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
            n_errors++;
        endtask

        task check_result(t_decode_res got);
            t_decode_res exp;
            if (pending.size() == 0) begin
                report("unexpected result", 32'(got), 32'd0);
                return;
            end
            exp = pending.pop_front();
            if (got.message !== exp.message)
                report("message", 32'(got.message), 32'(exp.message));
            if (got.status !== exp.status)
                report("status", 32'(got.status), 32'(exp.status));
            if (got.iters !== exp.iters)
                report("iterations_used", 32'(got.iters), 32'(exp.iters));
        endtask
    endclass
endpackage

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// directed and random received words through the bit-flip decoder, checked
// against an in-bench decode model under several key, margin and limit settings
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qcbf_pkg::*;
    import qcbf_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    decode_scoreboard board;

    qcbf_in_if  in_ch();
    qcbf_out_if out_ch();

    qc_mdpc_bit_flip_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.received_word = '0;
        out_ch.ready = 1'b0;
    end

    // write one register while the decoder is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one received word after a random gap, hold until accepted
    task automatic send_word(logic [WORD_W-1:0] w, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.received_word <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_word(w);
        in_ch.valid <= 1'b0;
        // decoder is busy right after an accept
        @(posedge i_clk);
    endtask

    // pause until every result is back, then let the decoder settle
    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_all(logic [23:0] key, logic [5:0] margin, logic [5:0] lim);
        wait_drained();
        write_reg(REG_KEY_ROW, key);
        write_reg(REG_MARGIN, margin);
        write_reg(REG_MAX_ITER, lim);
    endtask

    // random word: mostly light errors on the all-zero codeword, some noise
    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 3))
            0: w = 24'($urandom());
            1: w = 24'(1) << $urandom_range(0, 23);
            2: w = (24'(1) << $urandom_range(0, 23)) | (24'(1) << $urandom_range(0, 23));
            default: w = 24'($urandom() & $urandom() & $urandom());
        endcase
        return w;
    endfunction

    // result side: random stalls, check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result('{out_ch.message, out_ch.status, out_ch.iterations_used});
    end

    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        logic [23:0] keys[6];
        board = new();
        keys = '{24'h0, 24'hFFFFFF, 24'h9A3C65, 24'h412208, 24'h0B16A5, 24'h5D28E1};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings with zero key, then extremes
        send_word(24'h000000);
        send_word(24'hFFFFFF);
        set_all(24'h9A3C65, 6'd0, 6'd10);
        send_word(24'h000000, 1);
        send_word(24'hFFFFFF, 1);
        send_word(24'h000001);
        send_word(24'h800000);
        send_word(24'h000040);
        send_word(24'h555555);
        send_word(24'hAAAAAA);
        // margin above the max count: every bit flips
        set_all(24'h9A3C65, 6'd63, 6'd1);
        send_word(24'h000003);
        send_word(24'hFFFFFF);
        // iteration limit at zero and at the top
        set_all(24'hFFFFFF, 6'd0, 6'd0);
        send_word(24'h000001);
        send_word(24'h000000);
        set_all(24'h412208, 6'd1, 6'd63);
        send_word(24'h000101);
        send_word(24'hC00003);
        send_word(24'h3F0000);

        for (int ph = 0; ph < 9; ph++) begin
            set_all((ph < 6) ? keys[ph] : 24'($urandom()),
                    (ph == 0) ? 6'd63 : 6'($urandom_range(0, 3)),
                    (ph == 1) ? 6'd63 : 6'($urandom_range(1, 12)));
            for (int i = 0; i < 150; i++) send_word(rand_word());
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (board.n_errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // worst case ~1400 items, about 44 ms
    initial begin
        #250ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: qc_mdpc_bit_flip_decoder.f
hw/rtl/qcbf_pkg.sv
hw/rtl/qcbf_in_if.sv
hw/rtl/qcbf_out_if.sv
hw/rtl/qc_mdpc_bit_flip_decoder.sv
tb/qcbf_scoreboard.sv
tb/testbench.sv
